// File: rtl/core/ptsa_pkg.sv
// Package: shared types and codes of the page-table slab allocator.
`timescale 1ns / 1ps
package ptsa_pkg;

    typedef enum logic [2:0] {
        OP_ALLOC_L1   = 3'd0,
        OP_ALLOC_L2   = 3'd1,
        OP_ALLOC_PAGE = 3'd2,
        OP_FREE_L1    = 3'd3,
        OP_FREE_L2    = 3'd4,
        OP_FREE_PAGE  = 3'd5,
        OP_NOP6       = 3'd6,
        OP_NOP7       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_UNUSED = 2'd0,
        KIND_L1     = 2'd1,
        KIND_L2     = 2'd2,
        KIND_PAGE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_E,
        S_DECIDE,
        S_FIX_RD,
        S_FIX_WR,
        S_E_WR,
        S_FINISH
    } fsm_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [9:0] slice_index;
        logic [3:0] sub_index;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] granted_slice;
        logic [3:0] granted_slot;
    } rsp_t;

endpackage

// File: rtl/core/page_table_slab_allocator_unit.sv
// Top level: slab allocator for page-table slices with LIFO free and partial lists.
`timescale 1ns / 1ps
// Flow: a no-op or an early reject goes straight to the finish state; a reject after the
//   slice read passes the read and decide states; a full update adds fixups and the slice write.
// Throughput: one request at a time; the block returns to idle as the response loads,
//   and a stalled response holds the block in its finish state.
// Reset: asynchronous, active low. After reset the block runs a clearing pass that
//   writes every slice and builds the unused list, with req_ready low throughout.
module page_table_slab_allocator_unit #(
    parameter int SLICE_COUNT      = 1024,
    parameter int TABLES_PER_SLICE = 16,
    parameter int PAGES_PER_SLICE  = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ptsa_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ptsa_pkg::rsp_t  rsp
);

    // Link width holds SLICE_COUNT itself, which is the null link.
    localparam int LW = $clog2(SLICE_COUNT + 1);
    localparam int IW = (SLICE_COUNT > 1) ? $clog2(SLICE_COUNT) : 1;
    localparam int EW = 18 + 2 * LW;
    localparam logic [LW-1:0] NIL  = LW'(SLICE_COUNT);
    localparam logic [LW-1:0] LAST = LW'(SLICE_COUNT - 1);
    localparam logic [15:0] TFULL = 16'((32'd1 << TABLES_PER_SLICE) - 32'd1);
    localparam logic [15:0] PFULL = 16'((32'd1 << PAGES_PER_SLICE) - 32'd1);

    // Slice memory: {kind, fill mask, next link, prev link} per slice.
    logic [EW-1:0] mem [SLICE_COUNT];
    logic [EW-1:0] rd_data_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_raddr;
    logic [EW-1:0] mem_wdata;

    ptsa_pkg::fsm_t state_reg, state_next;

    logic [2:0]    op_reg, op_next;
    logic [LW-1:0] s_reg, s_next;
    logic [3:0]    slot_reg, slot_next;
    logic [1:0]    e_kind_reg, e_kind_next;
    logic [15:0]   e_mask_reg, e_mask_next;
    logic [LW-1:0] e_nx_reg, e_nx_next;
    logic [LW-1:0] e_pv_reg, e_pv_next;
    logic [LW-1:0] uhead_reg, uhead_next;
    logic [LW-1:0] thead_reg, thead_next;
    logic [LW-1:0] phead_reg, phead_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;

    // Pending neighbor link fixups, applied in order.
    logic [LW-1:0] fix_addr_reg [3];
    logic [LW-1:0] fix_addr_next [3];
    logic [LW-1:0] fix_val_reg [3];
    logic [LW-1:0] fix_val_next [3];
    logic [2:0]    fix_is_nx_reg, fix_is_nx_next;
    logic [2:0]    fix_vld_reg, fix_vld_next;
    logic [1:0]    fix_idx_reg, fix_idx_next;

    ptsa_pkg::rsp_t res_reg, res_next;
    ptsa_pkg::rsp_t rsp_reg, rsp_next;
    logic           rsp_valid_reg, rsp_valid_next;

    // Decode of the registered read word.
    logic [1:0]    rd_kind;
    logic [15:0]   rd_mask;
    logic [LW-1:0] rd_nx;
    logic [LW-1:0] rd_pv;

    logic          rsp_free;
    logic          is_table;
    int            slots;
    logic [15:0]   full_m;
    logic [LW-1:0] khead;
    logic [1:0]    kkind;
    logic          enc_found;
    logic [3:0]    enc_slot;
    logic [15:0]   slot_bit;

    assign rd_pv   = rd_data_reg[LW-1:0];
    assign rd_nx   = rd_data_reg[2*LW-1:LW];
    assign rd_mask = rd_data_reg[2*LW+15:2*LW];
    assign rd_kind = rd_data_reg[2*LW+17:2*LW+16];

    assign req_ready = (state_reg == ptsa_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Per-kind selection follows the latched operation.
    assign is_table = (op_reg == ptsa_pkg::OP_ALLOC_L2) || (op_reg == ptsa_pkg::OP_FREE_L2);
    assign slots    = is_table ? TABLES_PER_SLICE : PAGES_PER_SLICE;
    assign full_m   = is_table ? TFULL : PFULL;
    assign khead    = is_table ? thead_reg : phead_reg;
    assign kkind    = is_table ? ptsa_pkg::KIND_L2 : ptsa_pkg::KIND_PAGE;
    assign slot_bit = 16'(1) << slot_reg;

    // Lowest free slot of the read slice.
    always_comb
    begin
        enc_found = 1'b0;
        enc_slot  = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (!enc_found && i < slots && !rd_mask[i])
            begin
                enc_found = 1'b1;
                enc_slot  = 4'(i);
            end
        end
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptsa_pkg::S_CLEAR:
            begin
                if (LW'(clr_idx_reg) == LAST)
                begin
                    state_next = ptsa_pkg::S_IDLE;
                end
            end
            ptsa_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ptsa_pkg::S_FINISH;
                    case (req.operation)
                        ptsa_pkg::OP_ALLOC_L1:
                        begin
                            if (uhead_reg != NIL)
                            begin
                                state_next = ptsa_pkg::S_RD_E;
                            end
                        end
                        ptsa_pkg::OP_ALLOC_L2:
                        begin
                            if (thead_reg != NIL || uhead_reg != NIL)
                            begin
                                state_next = ptsa_pkg::S_RD_E;
                            end
                        end
                        ptsa_pkg::OP_ALLOC_PAGE:
                        begin
                            if (phead_reg != NIL || uhead_reg != NIL)
                            begin
                                state_next = ptsa_pkg::S_RD_E;
                            end
                        end
                        ptsa_pkg::OP_FREE_L1:
                        begin
                            if (32'(req.slice_index) < SLICE_COUNT)
                            begin
                                state_next = ptsa_pkg::S_RD_E;
                            end
                        end
                        ptsa_pkg::OP_FREE_L2:
                        begin
                            if (32'(req.slice_index) < SLICE_COUNT &&
                                32'(req.sub_index) < TABLES_PER_SLICE)
                            begin
                                state_next = ptsa_pkg::S_RD_E;
                            end
                        end
                        ptsa_pkg::OP_FREE_PAGE:
                        begin
                            if (32'(req.slice_index) < SLICE_COUNT &&
                                32'(req.sub_index) < PAGES_PER_SLICE)
                            begin
                                state_next = ptsa_pkg::S_RD_E;
                            end
                        end
                        default:
                        begin
                            state_next = ptsa_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            ptsa_pkg::S_RD_E:
            begin
                state_next = ptsa_pkg::S_DECIDE;
            end
            ptsa_pkg::S_DECIDE:
            begin
                state_next = ptsa_pkg::S_FIX_RD;
                case (op_reg)
                    ptsa_pkg::OP_ALLOC_L2, ptsa_pkg::OP_ALLOC_PAGE:
                    begin
                        if (khead != NIL && !enc_found)
                        begin
                            state_next = ptsa_pkg::S_FINISH;
                        end
                    end
                    ptsa_pkg::OP_FREE_L1:
                    begin
                        if (rd_kind != ptsa_pkg::KIND_L1)
                        begin
                            state_next = ptsa_pkg::S_FINISH;
                        end
                    end
                    ptsa_pkg::OP_FREE_L2, ptsa_pkg::OP_FREE_PAGE:
                    begin
                        if (rd_kind != kkind || (rd_mask & slot_bit) == 16'd0)
                        begin
                            state_next = ptsa_pkg::S_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = ptsa_pkg::S_FIX_RD;
                    end
                endcase
            end
            ptsa_pkg::S_FIX_RD:
            begin
                if (fix_vld_reg[fix_idx_reg])
                begin
                    state_next = ptsa_pkg::S_FIX_WR;
                end
                else if (fix_idx_reg == 2'd2)
                begin
                    state_next = ptsa_pkg::S_E_WR;
                end
            end
            ptsa_pkg::S_FIX_WR:
            begin
                state_next = (fix_idx_reg == 2'd2) ? ptsa_pkg::S_E_WR : ptsa_pkg::S_FIX_RD;
            end
            ptsa_pkg::S_E_WR:
            begin
                state_next = ptsa_pkg::S_FINISH;
            end
            ptsa_pkg::S_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ptsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptsa_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and memory port control.
    always_comb
    begin
        logic [LW-1:0] nh;
        logic [15:0]   nmask;

        op_next        = op_reg;
        s_next         = s_reg;
        slot_next      = slot_reg;
        e_kind_next    = e_kind_reg;
        e_mask_next    = e_mask_reg;
        e_nx_next      = e_nx_reg;
        e_pv_next      = e_pv_reg;
        uhead_next     = uhead_reg;
        thead_next     = thead_reg;
        phead_next     = phead_reg;
        clr_idx_next   = clr_idx_reg;
        fix_addr_next  = fix_addr_reg;
        fix_val_next   = fix_val_reg;
        fix_is_nx_next = fix_is_nx_reg;
        fix_vld_next   = fix_vld_reg;
        fix_idx_next   = fix_idx_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        mem_waddr      = s_reg[IW-1:0];
        mem_raddr      = s_reg[IW-1:0];
        mem_wdata      = {e_kind_reg, e_mask_reg, e_nx_reg, e_pv_reg};
        nh             = khead;
        nmask          = rd_mask;

        unique case (state_reg)
            ptsa_pkg::S_CLEAR:
            begin
                // Chain slice i to i-1 and i+1; the ends hold null.
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = {ptsa_pkg::KIND_UNUSED, 16'd0,
                                (clr_idx_reg == '0) ? NIL : LW'(clr_idx_reg) - LW'(1),
                                (LW'(clr_idx_reg) == LAST) ? NIL : LW'(clr_idx_reg) + LW'(1)};
                clr_idx_next = clr_idx_reg + IW'(1);
            end
            ptsa_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req.operation;
                    slot_next    = req.sub_index;
                    s_next       = LW'(req.slice_index);
                    fix_vld_next = '0;
                    fix_idx_next = '0;
                    res_next     = '{status: ptsa_pkg::ST_OK, granted_slice: '0,
                                     granted_slot: '0};
                    case (req.operation)
                        ptsa_pkg::OP_ALLOC_L1:
                        begin
                            s_next = uhead_reg;
                            if (uhead_reg == NIL)
                            begin
                                res_next.status = ptsa_pkg::ST_OOM;
                            end
                        end
                        ptsa_pkg::OP_ALLOC_L2:
                        begin
                            s_next = (thead_reg != NIL) ? thead_reg : uhead_reg;
                            if (thead_reg == NIL && uhead_reg == NIL)
                            begin
                                res_next.status = ptsa_pkg::ST_OOM;
                            end
                        end
                        ptsa_pkg::OP_ALLOC_PAGE:
                        begin
                            s_next = (phead_reg != NIL) ? phead_reg : uhead_reg;
                            if (phead_reg == NIL && uhead_reg == NIL)
                            begin
                                res_next.status = ptsa_pkg::ST_OOM;
                            end
                        end
                        ptsa_pkg::OP_FREE_L1:
                        begin
                            if (32'(req.slice_index) >= SLICE_COUNT)
                            begin
                                res_next.status = ptsa_pkg::ST_BAD_FREE;
                            end
                        end
                        ptsa_pkg::OP_FREE_L2:
                        begin
                            if (32'(req.slice_index) >= SLICE_COUNT ||
                                32'(req.sub_index) >= TABLES_PER_SLICE)
                            begin
                                res_next.status = ptsa_pkg::ST_BAD_FREE;
                            end
                        end
                        ptsa_pkg::OP_FREE_PAGE:
                        begin
                            if (32'(req.slice_index) >= SLICE_COUNT ||
                                32'(req.sub_index) >= PAGES_PER_SLICE)
                            begin
                                res_next.status = ptsa_pkg::ST_BAD_FREE;
                            end
                        end
                        default:
                        begin
                            res_next.status = ptsa_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ptsa_pkg::S_RD_E:
            begin
                mem_raddr = s_reg[IW-1:0];
            end
            ptsa_pkg::S_DECIDE:
            begin
                e_kind_next = rd_kind;
                e_mask_next = rd_mask;
                e_nx_next   = rd_nx;
                e_pv_next   = rd_pv;
                case (op_reg)
                    ptsa_pkg::OP_ALLOC_L1:
                    begin
                        // Pop the unused head.
                        uhead_next       = rd_nx;
                        fix_vld_next[0]  = (rd_nx != NIL);
                        fix_addr_next[0] = rd_nx;
                        fix_is_nx_next[0] = 1'b0;
                        fix_val_next[0]  = NIL;
                        e_kind_next      = ptsa_pkg::KIND_L1;
                        e_mask_next      = '0;
                        e_nx_next        = NIL;
                        e_pv_next        = NIL;
                        res_next.granted_slice = 10'(s_reg);
                    end
                    ptsa_pkg::OP_ALLOC_L2, ptsa_pkg::OP_ALLOC_PAGE:
                    begin
                        if (khead != NIL)
                        begin
                            if (!enc_found)
                            begin
                                res_next.status = ptsa_pkg::ST_OOM;
                            end
                            else
                            begin
                                nmask       = rd_mask | (16'(1) << enc_slot);
                                e_mask_next = nmask;
                                res_next.granted_slice = 10'(s_reg);
                                res_next.granted_slot  = enc_slot;
                                if ((nmask & full_m) == full_m)
                                begin
                                    // Full: drop it from the partial list.
                                    if (is_table)
                                    begin
                                        thead_next = rd_nx;
                                    end
                                    else
                                    begin
                                        phead_next = rd_nx;
                                    end
                                    fix_vld_next[0]   = (rd_nx != NIL);
                                    fix_addr_next[0]  = rd_nx;
                                    fix_is_nx_next[0] = 1'b0;
                                    fix_val_next[0]   = NIL;
                                    e_nx_next         = NIL;
                                    e_pv_next         = NIL;
                                end
                            end
                        end
                        else
                        begin
                            // Fresh slice from the unused list onto the empty partial list.
                            uhead_next        = rd_nx;
                            fix_vld_next[0]   = (rd_nx != NIL);
                            fix_addr_next[0]  = rd_nx;
                            fix_is_nx_next[0] = 1'b0;
                            fix_val_next[0]   = NIL;
                            e_kind_next       = kkind;
                            e_mask_next       = 16'h0001;
                            e_nx_next         = NIL;
                            e_pv_next         = NIL;
                            if (is_table)
                            begin
                                thead_next = s_reg;
                            end
                            else
                            begin
                                phead_next = s_reg;
                            end
                            res_next.granted_slice = 10'(s_reg);
                        end
                    end
                    ptsa_pkg::OP_FREE_L1:
                    begin
                        if (rd_kind != ptsa_pkg::KIND_L1)
                        begin
                            res_next.status = ptsa_pkg::ST_BAD_FREE;
                        end
                        else
                        begin
                            fix_vld_next[0]   = (uhead_reg != NIL);
                            fix_addr_next[0]  = uhead_reg;
                            fix_is_nx_next[0] = 1'b0;
                            fix_val_next[0]   = s_reg;
                            e_kind_next       = ptsa_pkg::KIND_UNUSED;
                            e_mask_next       = '0;
                            e_nx_next         = uhead_reg;
                            e_pv_next         = NIL;
                            uhead_next        = s_reg;
                        end
                    end
                    ptsa_pkg::OP_FREE_L2, ptsa_pkg::OP_FREE_PAGE:
                    begin
                        if (rd_kind != kkind || (rd_mask & slot_bit) == 16'd0)
                        begin
                            res_next.status = ptsa_pkg::ST_BAD_FREE;
                        end
                        else
                        begin
                            if ((rd_mask & full_m) != full_m)
                            begin
                                // Unlink from the partial list.
                                fix_vld_next[0]   = (rd_nx != NIL);
                                fix_addr_next[0]  = rd_nx;
                                fix_is_nx_next[0] = 1'b0;
                                fix_val_next[0]   = rd_pv;
                                fix_vld_next[1]   = (rd_pv != NIL);
                                fix_addr_next[1]  = rd_pv;
                                fix_is_nx_next[1] = 1'b1;
                                fix_val_next[1]   = rd_nx;
                                if (rd_pv == NIL)
                                begin
                                    nh = rd_nx;
                                end
                            end
                            nmask       = rd_mask & ~slot_bit;
                            e_mask_next = nmask;
                            e_pv_next   = NIL;
                            fix_is_nx_next[2] = 1'b0;
                            fix_val_next[2]   = s_reg;
                            if (nmask == 16'd0)
                            begin
                                // Emptied: return to the unused list.
                                e_kind_next      = ptsa_pkg::KIND_UNUSED;
                                fix_vld_next[2]  = (uhead_reg != NIL);
                                fix_addr_next[2] = uhead_reg;
                                e_nx_next        = uhead_reg;
                                uhead_next       = s_reg;
                            end
                            else
                            begin
                                fix_vld_next[2]  = (nh != NIL);
                                fix_addr_next[2] = nh;
                                e_nx_next        = nh;
                                nh               = s_reg;
                            end
                            if (is_table)
                            begin
                                thead_next = nh;
                            end
                            else
                            begin
                                phead_next = nh;
                            end
                        end
                    end
                    default:
                    begin
                        res_next = res_reg;
                    end
                endcase
            end
            ptsa_pkg::S_FIX_RD:
            begin
                mem_raddr = fix_addr_reg[fix_idx_reg][IW-1:0];
                if (!fix_vld_reg[fix_idx_reg] && fix_idx_reg != 2'd2)
                begin
                    fix_idx_next = fix_idx_reg + 2'd1;
                end
            end
            ptsa_pkg::S_FIX_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = fix_addr_reg[fix_idx_reg][IW-1:0];
                if (fix_is_nx_reg[fix_idx_reg])
                begin
                    mem_wdata = {rd_data_reg[EW-1:2*LW], fix_val_reg[fix_idx_reg], rd_pv};
                end
                else
                begin
                    mem_wdata = {rd_data_reg[EW-1:LW], fix_val_reg[fix_idx_reg]};
                end
                if (fix_idx_reg != 2'd2)
                begin
                    fix_idx_next = fix_idx_reg + 2'd1;
                end
            end
            ptsa_pkg::S_E_WR:
            begin
                mem_we = 1'b1;
            end
            ptsa_pkg::S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptsa_pkg::S_CLEAR;
            clr_idx_reg   <= '0;
            uhead_reg     <= LAST;
            thead_reg     <= NIL;
            phead_reg     <= NIL;
            fix_idx_reg   <= '0;
            fix_vld_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            uhead_reg     <= uhead_next;
            thead_reg     <= thead_next;
            phead_reg     <= phead_next;
            fix_idx_reg   <= fix_idx_next;
            fix_vld_reg   <= fix_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        s_reg         <= s_next;
        slot_reg      <= slot_next;
        e_kind_reg    <= e_kind_next;
        e_mask_reg    <= e_mask_next;
        e_nx_reg      <= e_nx_next;
        e_pv_reg      <= e_pv_next;
        fix_addr_reg  <= fix_addr_next;
        fix_val_reg   <= fix_val_next;
        fix_is_nx_reg <= fix_is_nx_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    // No memory write while waiting for a request.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ptsa_pkg::S_IDLE |-> !mem_we)
        else $error("slice memory written while idle");

    // A finished request always lands in the response register.
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptsa_pkg::S_FINISH && rsp_free) |=> rsp_valid_reg)
        else $error("response not loaded");

    // List heads stay within the slice range or null.
    a_heads_range: assert property (@(posedge clk) disable iff (!rst_n)
        uhead_reg <= NIL && thead_reg <= NIL && phead_reg <= NIL)
        else $error("list head out of range");

    // Fixup walk never runs past its three slots.
    a_fix_idx: assert property (@(posedge clk) disable iff (!rst_n)
        fix_idx_reg != 2'd3)
        else $error("fixup index overrun");

endmodule

// File: sim/page_table_slab_allocator_unit_tb.sv
// Testbench: random and directed request stream against a behavioral slab allocator predictor.
`timescale 1ns / 1ps
module page_table_slab_allocator_unit_tb;

    localparam int SLICES = 1024;
    localparam int TABLES = 16;
    localparam int PAGES  = 4;
    localparam int NIL    = SLICES;
    localparam int CYCLE_LIMIT = 900000;

    // Scoreboard: owns the allocator predictor state and the queue of expected responses.
    class slab_scoreboard;
        ptsa_pkg::kind_t kind_of[SLICES];
        logic [15:0]     mask_of[SLICES];
        int              fwd[SLICES];
        int              back[SLICES];
        int              unused_top, table_top, page_top;
        ptsa_pkg::rsp_t  pending[$];
        int              mismatches;
        int              checked;
        int              oom_seen, bad_seen;

        function void clear_state();
            for (int i = 0; i < SLICES; i++)
            begin
                kind_of[i] = ptsa_pkg::KIND_UNUSED;
                mask_of[i] = '0;
                fwd[i] = (i == 0) ? NIL : i - 1;
                back[i] = (i + 1 < SLICES) ? i + 1 : NIL;
            end
            unused_top = SLICES - 1;
            table_top = NIL;
            page_top = NIL;
            pending.delete();
            mismatches = 0;
            checked = 0;
            oom_seen = 0;
            bad_seen = 0;
        endfunction

        function void push_front(ref int top, input int s);
            if (top < SLICES)
                back[top] = s;
            fwd[s] = top;
            back[s] = NIL;
            top = s;
        endfunction

        function int pop_front(ref int top);
            int s;
            int nx;
            s = top;
            nx = fwd[s];
            top = nx;
            if (nx < SLICES)
                back[nx] = NIL;
            fwd[s] = NIL;
            back[s] = NIL;
            return s;
        endfunction

        function void unlink(ref int top, input int s);
            int nx;
            int pv;
            nx = fwd[s];
            pv = back[s];
            if (nx < SLICES)
                back[nx] = pv;
            if (pv < SLICES)
                fwd[pv] = nx;
            else
                top = nx;
            fwd[s] = NIL;
            back[s] = NIL;
        endfunction

        function void grant_sub(ref int top, input ptsa_pkg::kind_t k, input int slots,
                                inout ptsa_pkg::rsp_t r);
            logic [15:0] full;
            int s;
            int slot;
            full = (16'h1 << slots) - 16'h1;
            if (top < SLICES)
            begin
                s = top;
                for (slot = 0; slot < slots; slot++)
                    if (!mask_of[s][slot])
                        break;
                if (slot >= slots)
                begin
                    r.status = ptsa_pkg::ST_OOM;
                    return;
                end
                mask_of[s][slot] = 1'b1;
                if ((mask_of[s] & full) == full)
                    void'(pop_front(top));
            end
            else
            begin
                if (unused_top >= SLICES)
                begin
                    r.status = ptsa_pkg::ST_OOM;
                    return;
                end
                s = pop_front(unused_top);
                kind_of[s] = k;
                mask_of[s] = 16'h0001;
                slot = 0;
                push_front(top, s);
            end
            r.granted_slice = s[9:0];
            r.granted_slot = slot[3:0];
        endfunction

        function void release_sub(ref int top, input ptsa_pkg::kind_t k, input int slots,
                                  input int s, input int slot, inout ptsa_pkg::rsp_t r);
            logic [15:0] full;
            full = (16'h1 << slots) - 16'h1;
            if (s >= SLICES || kind_of[s] != k || slot >= slots || !mask_of[s][slot])
            begin
                r.status = ptsa_pkg::ST_BAD_FREE;
                return;
            end
            if ((mask_of[s] & full) != full)
                unlink(top, s);
            mask_of[s][slot] = 1'b0;
            if (mask_of[s] == 0)
            begin
                kind_of[s] = ptsa_pkg::KIND_UNUSED;
                push_front(unused_top, s);
            end
            else
                push_front(top, s);
        endfunction

        // Note an accepted request word: advance the predictor and queue its response.
        function void note_request(ptsa_pkg::req_t q);
            ptsa_pkg::rsp_t r;
            int s;
            r = '0;
            s = q.slice_index;
            case (ptsa_pkg::op_t'(q.operation))
                ptsa_pkg::OP_ALLOC_L1:
                begin
                    if (unused_top >= SLICES)
                        r.status = ptsa_pkg::ST_OOM;
                    else
                    begin
                        s = pop_front(unused_top);
                        kind_of[s] = ptsa_pkg::KIND_L1;
                        mask_of[s] = '0;
                        r.granted_slice = s[9:0];
                    end
                end
                ptsa_pkg::OP_ALLOC_L2:
                    grant_sub(table_top, ptsa_pkg::KIND_L2, TABLES, r);
                ptsa_pkg::OP_ALLOC_PAGE:
                    grant_sub(page_top, ptsa_pkg::KIND_PAGE, PAGES, r);
                ptsa_pkg::OP_FREE_L1:
                begin
                    if (kind_of[s] != ptsa_pkg::KIND_L1)
                        r.status = ptsa_pkg::ST_BAD_FREE;
                    else
                    begin
                        kind_of[s] = ptsa_pkg::KIND_UNUSED;
                        mask_of[s] = '0;
                        push_front(unused_top, s);
                    end
                end
                ptsa_pkg::OP_FREE_L2:
                    release_sub(table_top, ptsa_pkg::KIND_L2, TABLES, s, q.sub_index, r);
                ptsa_pkg::OP_FREE_PAGE:
                    release_sub(page_top, ptsa_pkg::KIND_PAGE, PAGES, s, q.sub_index, r);
                default: ;
            endcase
            if (r.status == ptsa_pkg::ST_OOM)
                oom_seen++;
            if (r.status == ptsa_pkg::ST_BAD_FREE)
                bad_seen++;
            pending.push_back(r);
        endfunction

        // Check a response word against the oldest expectation.
        function void check_response(ptsa_pkg::rsp_t got);
            ptsa_pkg::rsp_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.granted_slice !== want.granted_slice ||
                got.granted_slot !== want.granted_slot)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response %0d: expected st=%0d slice=%0d slot=%0d, %s%0d %s%0d %s%0d",
                             checked, want.status, want.granted_slice, want.granted_slot,
                             "got st=", got.status, "slice=", got.granted_slice,
                             "slot=", got.granted_slot);
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    ptsa_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    ptsa_pkg::rsp_t rsp;

    slab_scoreboard board;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     cycle_count;
    int     req_count;

    // Live objects we hold, so frees can target real slots most of the time.
    int     held_l1[$];
    int     held_l2[$];
    int     held_pg[$];

    page_table_slab_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sample the response handshake at the edge; requests are noted by the driver.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                board.check_response(rsp);
        end
    end

    // Receiver: stall at the current rate, decided fresh each edge.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Drive one request word: optional idle gap, then hold valid until accepted.
    task automatic send_word(input logic [2:0] op, input logic [9:0] s, input logic [3:0] slot);
        ptsa_pkg::req_t w;
        w.operation = op;
        w.slice_index = s;
        w.sub_index = slot;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
        board.note_request(w);
        req_count++;
    endtask

    // Drop valid and wait for every queued response to come back.
    task automatic drain();
        req_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Pull a random entry out of a holding queue.
    function automatic int take_any(ref int q[$]);
        int k;
        int v;
        k = $urandom_range(q.size() - 1);
        v = q[k];
        q.delete(k);
        return v;
    endfunction

    // Send one allocation and record what the predictor says was granted.
    task automatic alloc_and_hold(input ptsa_pkg::op_t op);
        ptsa_pkg::rsp_t r;
        send_word(op, 10'($urandom), 4'($urandom));
        r = board.pending[board.pending.size() - 1];
        if (r.status == ptsa_pkg::ST_OK)
            case (op)
                ptsa_pkg::OP_ALLOC_L1:
                    held_l1.push_back(int'(r.granted_slice));
                ptsa_pkg::OP_ALLOC_L2:
                    held_l2.push_back(int'({r.granted_slice, r.granted_slot}));
                default:
                    held_pg.push_back(int'({r.granted_slice, r.granted_slot}));
            endcase
    endtask

    // Mostly well-formed alloc/free traffic, with a share of garbage frees and no-ops.
    task automatic random_word();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 12)
            alloc_and_hold(ptsa_pkg::OP_ALLOC_L1);
        else if (pick < 30)
            alloc_and_hold(ptsa_pkg::OP_ALLOC_L2);
        else if (pick < 48)
            alloc_and_hold(ptsa_pkg::OP_ALLOC_PAGE);
        else if (pick < 58 && held_l1.size() != 0)
            send_word(ptsa_pkg::OP_FREE_L1, 10'(take_any(held_l1)), 4'($urandom));
        else if (pick < 72 && held_l2.size() != 0)
        begin
            v = take_any(held_l2);
            send_word(ptsa_pkg::OP_FREE_L2, 10'(v >> 4), 4'(v));
        end
        else if (pick < 86 && held_pg.size() != 0)
        begin
            v = take_any(held_pg);
            send_word(ptsa_pkg::OP_FREE_PAGE, 10'(v >> 4), 4'(v));
        end
        else
            send_word(3'($urandom_range(7)), 10'($urandom), 4'($urandom));
    endtask

    initial
    begin
        int phase_pct[4][2];
        board = new();
        board.clear_state();
        phase_pct = '{'{0, 0}, '{81, 0}, '{0, 81}, '{17, 17}};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        req_count = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: each operation, bad frees of every flavor, no-ops, field extremes.
        alloc_and_hold(ptsa_pkg::OP_ALLOC_L1);
        alloc_and_hold(ptsa_pkg::OP_ALLOC_L2);
        alloc_and_hold(ptsa_pkg::OP_ALLOC_L2);
        alloc_and_hold(ptsa_pkg::OP_ALLOC_PAGE);
        send_word(ptsa_pkg::OP_FREE_L1, 10'd0, 4'd0);
        send_word(ptsa_pkg::OP_FREE_L2, 10'd1023, 4'd15);
        send_word(ptsa_pkg::OP_FREE_L2, 10'd1022, 4'd15);
        send_word(ptsa_pkg::OP_FREE_L2, 10'd1022, 4'd2);
        send_word(ptsa_pkg::OP_FREE_PAGE, 10'd1021, 4'd4);
        send_word(ptsa_pkg::OP_FREE_PAGE, 10'd1021, 4'd3);
        send_word(ptsa_pkg::OP_FREE_PAGE, 10'd1022, 4'd0);
        send_word(ptsa_pkg::OP_NOP6, 10'h3ff, 4'hf);
        send_word(ptsa_pkg::OP_NOP7, 10'h155, 4'ha);
        // Fill one page slice so it leaves the partial list, then free from the middle.
        repeat (3)
            alloc_and_hold(ptsa_pkg::OP_ALLOC_PAGE);
        send_word(ptsa_pkg::OP_FREE_PAGE, 10'd1021, 4'd1);
        alloc_and_hold(ptsa_pkg::OP_ALLOC_PAGE);
        send_word(ptsa_pkg::OP_FREE_L1, 10'd1023, 4'd0);
        send_word(ptsa_pkg::OP_FREE_L1, 10'd1023, 4'd0);
        drain();
        held_l1.delete();
        held_pg.delete();
        held_l2.delete();
        // Rebuild held lists from the predictor so random frees stay meaningful.
        for (int i = 0; i < SLICES; i++)
            for (int b = 0; b < 16; b++)
                if (board.mask_of[i][b])
                begin
                    if (board.kind_of[i] == ptsa_pkg::KIND_L2)
                        held_l2.push_back(int'({i[9:0], 4'(b)}));
                    else if (board.kind_of[i] == ptsa_pkg::KIND_PAGE)
                        held_pg.push_back(int'({i[9:0], 4'(b)}));
                end

        // Random phases across idling patterns.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            repeat (200)
                random_word();
            drain();
        end

        // Exhaust the pool with first-level tables to reach out-of-memory.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (board.unused_top < SLICES)
            alloc_and_hold(ptsa_pkg::OP_ALLOC_L1);
        alloc_and_hold(ptsa_pkg::OP_ALLOC_L1);
        alloc_and_hold(ptsa_pkg::OP_ALLOC_L2);
        alloc_and_hold(ptsa_pkg::OP_ALLOC_PAGE);
        repeat (50)
            random_word();
        drain();

        repeat (40)
            @(posedge clk);
        $display("requests sent %0d, responses checked %0d, out-of-memory %0d, bad frees %0d",
                 req_count, board.checked, board.oom_seen, board.bad_seen);
        $display("idle phases: none, sender 81%%, receiver 81%%, both 17%%; pool drained once");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
        begin
            $display("mismatches %0d, responses still owed %0d",
                     board.mismatches, board.pending.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
